[design/obr_pkg.sv]
package obr_pkg;

	localparam int MAX_BINS = 1024;
	localparam int SAMPLE_W = 16;
	localparam int WLEN_W   = 11;
	localparam int IDX_W    = 10;
	localparam int CORR_W   = SAMPLE_W + 1;
	localparam int STAT_W   = 2;
	// A window sum covers at most 2**(WLEN_W-1) samples.
	localparam int SUM_W    = SAMPLE_W + WLEN_W - 1;
	localparam int DCNT_W   = $clog2(SUM_W + 1);

	localparam logic [WLEN_W-1:0] WLEN_RESET = WLEN_W'(204);

	localparam logic KIND_LOAD = 1'b0;
	localparam logic KIND_READ = 1'b1;

	localparam logic [STAT_W-1:0] STAT_OK  = 2'd0;
	localparam logic [STAT_W-1:0] STAT_WIN = 2'd1;
	localparam logic [STAT_W-1:0] STAT_IDX = 2'd2;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic signed [SUM_W-1:0]    wsum_t;
	typedef logic [WLEN_W-1:0]          wlen_t;

	typedef struct packed {
		logic  start;
		wsum_t dividend;
		wlen_t divisor;
	} div_req_t;

	typedef struct packed {
		logic    done;
		sample_t quotient;
	} div_rsp_t;

endpackage

[design/obr_ifs.sv]
interface obr_item_if import obr_pkg::*; ();
	logic                valid;
	logic                ready;
	logic                kind;
	logic [SAMPLE_W-1:0] sample;
	logic                last_sample;
	logic [IDX_W-1:0]    read_index;

	modport source (output valid, kind, sample, last_sample, read_index, input ready);
	modport sink (input valid, kind, sample, last_sample, read_index, output ready);
endinterface

interface obr_result_if import obr_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [CORR_W-1:0]   corrected;
	logic [SAMPLE_W-1:0] baseline;
	logic [IDX_W-1:0]    window_start;
	logic [STAT_W-1:0]   status;

	modport source (output valid, corrected, baseline, window_start, status, input ready);
	modport sink (input valid, corrected, baseline, window_start, status, output ready);
endinterface

interface obr_cfg_if import obr_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [WLEN_W-1:0] window_length;

	modport source (output valid, window_length, input ready);
	modport sink (input valid, window_length, output ready);
endinterface

[design/obr_profile_mem.sv]
module obr_profile_mem import obr_pkg::*; #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10
) (
	input  logic                clk,
	input  logic                we,
	input  logic [AW-1:0]       waddr,
	input  logic [SAMPLE_W-1:0] wdata,
	input  logic [AW-1:0]       raddr_a,
	input  logic [AW-1:0]       raddr_b,
	output logic [SAMPLE_W-1:0] rdata_a,
	output logic [SAMPLE_W-1:0] rdata_b
);

	logic [SAMPLE_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

[design/obr_div.sv]
module obr_div import obr_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic              busy_q;
	logic              done_q;
	logic              neg_q;
	logic [DCNT_W-1:0] cnt_q;
	logic [WLEN_W-1:0] div_q;
	logic [WLEN_W-1:0] rem_q;
	logic [SUM_W-1:0]  quo_q;
	logic [WLEN_W:0]   trial;
	logic              fits;
	logic [SUM_W-1:0]  mag;
	logic [SUM_W-1:0]  signed_quo;

	// Restoring division on the magnitude; the dividend shifts out of quo_q
	// as the quotient bits shift in.
	assign trial = {rem_q, quo_q[SUM_W-1]};
	assign fits  = trial >= {1'b0, div_q};
	assign mag   = req.dividend[SUM_W-1] ? SUM_W'(-req.dividend) : SUM_W'(req.dividend);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= DCNT_W'(SUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - DCNT_W'(1);
				if (cnt_q == DCNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			neg_q <= req.dividend[SUM_W-1];
			div_q <= req.divisor;
			rem_q <= '0;
			quo_q <= mag;
		end else if (busy_q) begin
			rem_q <= fits ? WLEN_W'(trial - {1'b0, div_q}) : trial[WLEN_W-1:0];
			quo_q <= {quo_q[SUM_W-2:0], fits};
		end
	end

	assign signed_quo   = neg_q ? (~quo_q + SUM_W'(1)) : quo_q;
	assign rsp.done     = done_q;
	assign rsp.quotient = signed_quo[SAMPLE_W-1:0];

endmodule

[design/offpulse_baseline_removal_unit.sv]
// Off-pulse baseline removal. Load a profile one sample per request (kind 0), flagging the
// final one; reads (kind 1) return a stored sample minus the current baseline. On the final
// load the unit searches every circular window of window_length bins for the smallest sum
// (a tie goes to the later start) and divides that sum by the window length, truncating
// toward zero, to get the baseline. A read waits for the result port to be free.
// A final load keeps the unit busy for the search, one window step per cycle, set by the
// two read ports of the profile memory feeding one shared adder, and then for the division,
// one quotient bit per cycle in the divider. A window of zero bins or one longer than the
// profile answers at once with status 1.
// window_length may be written only while the unit is idle.
module offpulse_baseline_removal_unit import obr_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	obr_item_if.sink     item,
	obr_result_if.source result,
	obr_cfg_if.sink      cfg
);

	localparam int AW   = $clog2(MAX_BINS);
	localparam int CW   = $clog2(MAX_BINS + 1);
	localparam int CMPW = (CW > WLEN_W) ? ((CW > IDX_W) ? CW : IDX_W)
	                                    : ((WLEN_W > IDX_W) ? WLEN_W : IDX_W);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_READ  = 3'd1;
	localparam logic [2:0] ST_INIT  = 3'd2;
	localparam logic [2:0] ST_SLIDE = 3'd3;
	localparam logic [2:0] ST_DRAIN = 3'd4;
	localparam logic [2:0] ST_DIV   = 3'd5;
	localparam logic [2:0] ST_DONE  = 3'd6;

	logic [2:0]          state_q;
	wlen_t               len_q;
	logic [CW-1:0]       cnt_q;
	logic                profile_done_q;
	logic [CW-1:0]       n_q;
	logic [CW-1:0]       i_q;
	logic [CW-1:0]       enter_q;
	logic [IDX_W-1:0]    rd_idx_q;
	logic                rd_bad_q;
	wsum_t               sum_q;
	wsum_t               best_q;
	logic [AW-1:0]       start_q;
	sample_t             baseline_q;
	logic [STAT_W-1:0]   stat_q;

	logic                v_s1, slide_s1, last_s1;
	logic [AW-1:0]       pos_s1;
	logic                v_s2, slide_s2, last_s2;
	logic [AW-1:0]       pos_s2;
	logic signed [SAMPLE_W:0] delta_s2;

	logic                out_valid_q;
	logic [CORR_W-1:0]   out_corr_q;
	logic [SAMPLE_W-1:0] out_base_q;
	logic [IDX_W-1:0]    out_start_q;
	logic [STAT_W-1:0]   out_stat_q;

	logic                accept;
	logic                out_free;
	logic                out_load;
	logic [CW-1:0]       base_cnt;
	logic                store_ok;
	logic [CW-1:0]       new_cnt;
	logic                mem_we;
	logic [AW-1:0]       addr_a, addr_b;
	logic [SAMPLE_W-1:0] rdata_a, rdata_b;
	logic                init_last;
	logic                slide_last;
	logic                win_bad;
	wsum_t               sum_new;
	div_req_t            div_req;
	div_rsp_t            div_rsp;

	assign item.ready = (state_q == ST_IDLE);
	assign cfg.ready  = 1'b1;
	assign accept     = item.valid && item.ready;
	assign out_free   = !out_valid_q || result.ready;
	assign out_load   = out_free && ((state_q == ST_READ) || (state_q == ST_DONE));

	// A load after a finished profile starts a new one from bin zero.
	assign base_cnt = profile_done_q ? '0 : cnt_q;
	assign store_ok = base_cnt < CW'(MAX_BINS);
	assign new_cnt  = base_cnt + CW'(store_ok);
	assign mem_we   = accept && (item.kind == KIND_LOAD) && store_ok;
	assign win_bad  = (len_q == '0) || (CMPW'(len_q) > CMPW'(new_cnt));

	assign init_last  = CMPW'(i_q + CW'(1)) == CMPW'(len_q);
	assign slide_last = (i_q + CW'(1)) == n_q;

	always_comb begin
		addr_a = AW'(i_q - CW'(1));
		addr_b = AW'(enter_q);
		unique case (state_q)
			ST_IDLE: addr_a = AW'(item.read_index);
			ST_READ: addr_a = AW'(rd_idx_q);
			ST_INIT: addr_a = AW'(i_q);
			default: addr_a = AW'(i_q - CW'(1));
		endcase
	end

	obr_profile_mem #(.DEPTH(MAX_BINS), .AW(AW)) u_mem (
		.clk     (clk),
		.we      (mem_we),
		.waddr   (AW'(base_cnt)),
		.wdata   (item.sample),
		.raddr_a (addr_a),
		.raddr_b (addr_b),
		.rdata_a (rdata_a),
		.rdata_b (rdata_b)
	);

	assign div_req.start    = (state_q == ST_DRAIN) && !v_s1 && !v_s2;
	assign div_req.dividend = best_q;
	assign div_req.divisor  = len_q;

	obr_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign sum_new = sum_q + SUM_W'(delta_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			len_q          <= WLEN_RESET;
			cnt_q          <= '0;
			profile_done_q <= 1'b0;
			start_q        <= '0;
			baseline_q     <= '0;
			best_q         <= '0;
			v_s1           <= 1'b0;
			v_s2           <= 1'b0;
			out_valid_q    <= 1'b0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				len_q <= cfg.window_length;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && result.ready) begin
				out_valid_q <= 1'b0;
			end

			v_s1 <= (state_q == ST_INIT) || (state_q == ST_SLIDE);
			v_s2 <= v_s1;

			// Shared accumulator: window fill, then one slide step per cycle.
			if (v_s2) begin
				sum_q <= sum_new;
				if (!slide_s2) begin
					if (last_s2) begin
						best_q  <= sum_new;
						start_q <= '0;
					end
				end else if (sum_new <= best_q) begin
					best_q  <= sum_new;
					start_q <= pos_s2;
				end
			end

			unique case (state_q)
				ST_IDLE: begin
					if (accept && item.kind == KIND_READ) begin
						rd_idx_q <= item.read_index;
						rd_bad_q <= CMPW'(item.read_index) >= CMPW'(cnt_q);
						state_q  <= ST_READ;
					end else if (accept) begin
						cnt_q <= new_cnt;
						if (item.last_sample) begin
							profile_done_q <= 1'b1;
							n_q            <= new_cnt;
							if (win_bad) begin
								best_q     <= '0;
								start_q    <= '0;
								baseline_q <= '0;
								stat_q     <= STAT_WIN;
								state_q    <= ST_DONE;
							end else begin
								i_q     <= '0;
								sum_q   <= '0;
								stat_q  <= STAT_OK;
								state_q <= ST_INIT;
							end
						end else begin
							profile_done_q <= 1'b0;
						end
					end
				end
				ST_READ: begin
					if (out_free) begin
						out_base_q  <= baseline_q;
						out_start_q <= IDX_W'(start_q);
						if (rd_bad_q) begin
							out_corr_q <= '0;
							out_stat_q <= STAT_IDX;
						end else begin
							out_corr_q <= $signed({rdata_a[SAMPLE_W-1], rdata_a})
							            - $signed({baseline_q[SAMPLE_W-1], baseline_q});
							out_stat_q <= STAT_OK;
						end
						state_q <= ST_IDLE;
					end
				end
				ST_INIT: begin
					if (init_last) begin
						i_q     <= CW'(1);
						enter_q <= (CMPW'(len_q) == CMPW'(n_q)) ? '0 : CW'(len_q);
						state_q <= (n_q == CW'(1)) ? ST_DRAIN : ST_SLIDE;
					end else begin
						i_q <= i_q + CW'(1);
					end
				end
				ST_SLIDE: begin
					i_q     <= i_q + CW'(1);
					enter_q <= ((enter_q + CW'(1)) == n_q) ? '0 : enter_q + CW'(1);
					if (slide_last) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (div_req.start) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_rsp.done) begin
						baseline_q <= div_rsp.quotient;
						state_q    <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						out_corr_q  <= '0;
						out_base_q  <= baseline_q;
						out_start_q <= IDX_W'(start_q);
						out_stat_q  <= stat_q;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		slide_s1 <= (state_q == ST_SLIDE);
		last_s1  <= init_last;
		pos_s1   <= AW'(i_q);
		slide_s2 <= slide_s1;
		last_s2  <= last_s1;
		pos_s2   <= pos_s1;
		if (slide_s1) begin
			delta_s2 <= $signed({rdata_b[SAMPLE_W-1], rdata_b})
			          - $signed({rdata_a[SAMPLE_W-1], rdata_a});
		end else begin
			delta_s2 <= $signed({rdata_a[SAMPLE_W-1], rdata_a});
		end
	end

	assign result.valid        = out_valid_q;
	assign result.corrected    = out_corr_q;
	assign result.baseline     = out_base_q;
	assign result.window_start = out_start_q;
	assign result.status       = out_stat_q;

endmodule

[dv/tb_offpulse_baseline_removal_unit.sv]
module tb_offpulse_baseline_removal_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import obr_pkg::*;

	localparam int BINS = MAX_BINS;

	typedef struct {
		logic                kind;
		logic [SAMPLE_W-1:0] sample;
		logic                last_sample;
		logic [IDX_W-1:0]    read_index;
	} profile_req_t;

	typedef struct {
		logic [CORR_W-1:0]   corrected;
		logic [SAMPLE_W-1:0] baseline;
		logic [IDX_W-1:0]    window_start;
		logic [STAT_W-1:0]   status;
	} profile_ans_t;

	logic clk;
	logic arst_n;

	obr_item_if   item_ch();
	obr_result_if result_ch();
	obr_cfg_if    cfg_ch();

	offpulse_baseline_removal_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	profile_req_t requests_todo[$];
	profile_ans_t answers_due[$];

	int queued_count;
	int accepted_count;
	int send_idle_pct;
	int recv_stall_pct;
	int mismatch_count;
	int loads_seen;
	int reads_seen;
	int answers_checked;

	// Predicted state of the unit.
	int stored_bins[BINS];
	int stored_count;
	int win_len;
	int best_start_m;
	int baseline_m;
	bit profile_closed;

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	function automatic logic [STAT_W-1:0] search_min_window();
		longint run_sum;
		longint best_sum;
		int n;
		int len;
		int pick;
		n = stored_count;
		len = win_len;
		if (len == 0 || len > n) begin
			best_start_m = 0;
			baseline_m = 0;
			return STAT_WIN;
		end
		run_sum = 0;
		for (int i = 0; i < len; i++)
			run_sum += stored_bins[i];
		best_sum = run_sum;
		pick = 0;
		// Slide the circular window one bin at a time; ties move to the later start.
		for (int i = 1; i < n; i++) begin
			run_sum += stored_bins[(i + len - 1) % n] - stored_bins[i - 1];
			if (run_sum <= best_sum) begin
				best_sum = run_sum;
				pick = i;
			end
		end
		best_start_m = pick;
		baseline_m = int'(best_sum / len);
		return STAT_OK;
	endfunction

	function automatic void apply_request(profile_req_t rq);
		profile_ans_t a;
		if (rq.kind == KIND_LOAD) begin
			loads_seen++;
			if (profile_closed) begin
				stored_count = 0;
				profile_closed = 1'b0;
			end
			if (stored_count < BINS) begin
				stored_bins[stored_count] = int'($signed(rq.sample));
				stored_count++;
			end
			if (!rq.last_sample)
				return;
			profile_closed = 1'b1;
			a.status = search_min_window();
			a.corrected = '0;
		end else begin
			reads_seen++;
			if (int'(rq.read_index) >= stored_count) begin
				a.status = STAT_IDX;
				a.corrected = '0;
			end else begin
				a.status = STAT_OK;
				a.corrected = CORR_W'(stored_bins[rq.read_index] - baseline_m);
			end
		end
		a.baseline = SAMPLE_W'(baseline_m);
		a.window_start = IDX_W'(best_start_m);
		answers_due.push_back(a);
	endfunction

	function automatic void push_load(logic [SAMPLE_W-1:0] value, logic is_last);
		profile_req_t rq;
		rq.kind = KIND_LOAD;
		rq.sample = value;
		rq.last_sample = is_last;
		rq.read_index = IDX_W'($urandom);
		requests_todo.push_back(rq);
		queued_count++;
	endfunction

	function automatic void push_read(logic [IDX_W-1:0] idx);
		profile_req_t rq;
		rq.kind = KIND_READ;
		rq.sample = SAMPLE_W'($urandom);
		rq.last_sample = 1'($urandom);
		rq.read_index = idx;
		requests_todo.push_back(rq);
		queued_count++;
	endfunction

	task automatic wait_drained();
		while (accepted_count != queued_count || answers_due.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_window(int len);
		wait_drained();
		// A trailing non-final load may still be settling after the last answer.
		repeat (16) @(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.window_length <= WLEN_W'(len);
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		win_len = len;
	endtask

	task automatic queue_profile(int n, int pause_at);
		int style;
		int level;
		logic [SAMPLE_W-1:0] v;
		style = $urandom_range(3);
		level = $urandom_range(65535);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(9) == 0)
				push_read(IDX_W'($urandom_range(n)));
			case (style)
				0: v = SAMPLE_W'($urandom_range(65535));
				// Flat profile: every window ties.
				1: v = SAMPLE_W'(level);
				// Narrow pulse on a noisy floor.
				2: v = SAMPLE_W'(level + $urandom_range(15) + ((i > n / 3 && i < n / 2) ? 4000 : 0));
				default: v = $urandom_range(1) ? 16'h8000 : 16'h7fff;
			endcase
			push_load(v, i == n - 1);
			if (i + 1 == pause_at)
				wait_drained();
		end
		repeat ($urandom_range(5)) begin
			if ($urandom_range(4) == 0)
				push_read(IDX_W'($urandom_range(BINS - 1)));
			else
				push_read(IDX_W'($urandom_range(n - 1)));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		profile_req_t next_rq;
		if (!arst_n) begin
			item_ch.valid <= 1'b0;
		end else if (!item_ch.valid || item_ch.ready) begin
			if (requests_todo.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				next_rq = requests_todo.pop_front();
				item_ch.valid <= 1'b1;
				item_ch.kind <= next_rq.kind;
				item_ch.sample <= next_rq.sample;
				item_ch.last_sample <= next_rq.last_sample;
				item_ch.read_index <= next_rq.read_index;
			end else begin
				item_ch.valid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			result_ch.ready <= 1'b0;
		else
			result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		profile_req_t seen;
		profile_ans_t want;
		if (arst_n) begin
			if (item_ch.valid && item_ch.ready) begin
				seen.kind = item_ch.kind;
				seen.sample = item_ch.sample;
				seen.last_sample = item_ch.last_sample;
				seen.read_index = item_ch.read_index;
				apply_request(seen);
				accepted_count++;
			end
			if (result_ch.valid && result_ch.ready) begin
				if (answers_due.size() == 0) begin
					mismatch_count++;
					$display("%0t: unexpected answer corrected=%h baseline=%h start=%0d status=%0d",
						$time, result_ch.corrected, result_ch.baseline,
						result_ch.window_start, result_ch.status);
				end else begin
					want = answers_due.pop_front();
					answers_checked++;
					if (result_ch.corrected !== want.corrected ||
						result_ch.baseline !== want.baseline ||
						result_ch.window_start !== want.window_start ||
						result_ch.status !== want.status) begin
						mismatch_count++;
						$display("%0t: answer mismatch expected corrected=%h baseline=%h start=%0d status=%0d",
							$time, want.corrected, want.baseline, want.window_start, want.status);
						$display("%0t:                 actual corrected=%h baseline=%h start=%0d status=%0d",
							$time, result_ch.corrected, result_ch.baseline,
							result_ch.window_start, result_ch.status);
					end
				end
			end
		end
	end

	initial begin
		#5_000_000;
		$display("FAIL offpulse_baseline_removal_unit");
		$finish;
	end

	initial begin
		int win_choices[5];
		int idle_plan[4];
		int stall_plan[4];
		int batch_start;
		int w;
		int n;

		win_choices = '{1, 2, 6, 17, 45};
		idle_plan = '{0, 85, 0, 26};
		stall_plan = '{0, 0, 85, 26};
		arst_n = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.window_length = WLEN_RESET;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		win_len = int'(WLEN_RESET);
		stored_count = 0;
		best_start_m = 0;
		baseline_m = 0;
		profile_closed = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reads of an empty store, then a profile shorter than the reset window length.
		push_read(IDX_W'(0));
		push_read(IDX_W'(BINS - 1));
		push_load(SAMPLE_W'(100), 1'b0);
		push_load(SAMPLE_W'(-5), 1'b0);
		push_load(SAMPLE_W'(7), 1'b1);
		push_read(IDX_W'(2));

		// Single-bin window at the sample extremes; the tie goes to the later start.
		write_window(1);
		push_load(16'h7fff, 1'b0);
		push_load(16'h8000, 1'b0);
		push_load(SAMPLE_W'(5), 1'b0);
		push_load(16'h8000, 1'b1);
		push_read(IDX_W'(0));
		push_read(IDX_W'(1));
		push_read(IDX_W'(4));

		// Negative mean truncates toward zero; a read in the middle of a load.
		write_window(2);
		push_load(SAMPLE_W'(-4), 1'b0);
		push_read(IDX_W'(0));
		push_load(SAMPLE_W'(-3), 1'b0);
		push_load(SAMPLE_W'(9), 1'b0);
		push_load(SAMPLE_W'(8), 1'b1);

		// Best window wraps past the end of the profile.
		write_window(3);
		push_load(SAMPLE_W'(1), 1'b0);
		push_load(SAMPLE_W'(-50), 1'b0);
		push_load(SAMPLE_W'(2), 1'b0);
		push_load(SAMPLE_W'(3), 1'b0);
		push_load(SAMPLE_W'(-60), 1'b1);
		push_read(IDX_W'(4));

		write_window(0);
		push_load(SAMPLE_W'(5), 1'b1);
		write_window(2047);
		push_load(SAMPLE_W'(-1), 1'b1);

		for (int m = 0; m < 4; m++) begin
			send_idle_pct = idle_plan[m];
			recv_stall_pct = stall_plan[m];
			foreach (win_choices[k]) begin
				w = win_choices[k];
				write_window(w);
				batch_start = queued_count;
				while (queued_count - batch_start < 8) begin
					if (w > 1 && $urandom_range(9) == 0)
						n = $urandom_range(w - 1, 1);
					else
						n = w + $urandom_range(2 * w + 8);
					// Once per pattern the sender halts mid-profile until all answers are in.
					queue_profile(n, (k == 2 && queued_count == batch_start) ? n / 2 : 0);
				end
			end
		end

		// Overfilled store with a window as wide as the store: extra loads drop, the flag still closes.
		write_window(BINS);
		queue_profile(BINS + 6, 0);
		push_read(IDX_W'(BINS - 1));
		push_read(IDX_W'(BINS / 2));

		wait_drained();
		repeat (64) @(posedge clk);
		if (answers_due.size() != 0) begin
			mismatch_count++;
			$display("%0t: %0d answers never arrived", $time, answers_due.size());
		end
		$display("Run covered %0d loads and %0d reads with %0d answers checked,", loads_seen,
			reads_seen, answers_checked);
		$display("window lengths 0 to 2047 including a full store, under four idling patterns.");
		if (mismatch_count == 0)
			$display("PASS offpulse_baseline_removal_unit");
		else
			$display("FAIL offpulse_baseline_removal_unit");
		$finish;
	end

endmodule
